// ----- hdl/swms_pkg.sv -----
// Package for the sliding-window message statistics block.
// Holds widths, reset constants and the sequencer state type.
// No dependencies.
package swms_pkg;
  localparam int unsigned WindowDepth = 1024;
  localparam int unsigned LenBits = 16;
  localparam int unsigned TimeBits = 48;
  localparam int unsigned CntBits = 48;
  localparam int unsigned WcntBits = 11;
  localparam int unsigned WinRegBits = 27;
  localparam int unsigned MeanBits = 24;
  localparam int unsigned SumBits = 64;
  localparam logic [WinRegBits-1:0] WinReset = 27'd3600000;
  localparam logic [MeanBits-1:0] MeanMax = 24'd16776960;
  localparam logic CmdRecord = 1'b0;
  localparam logic CmdSnap = 1'b1;

  typedef enum logic [3:0] {
    StIdle, StPush, StRead, StCheck, StMeanA, StMeanB, StOut
  } state_e;
endpackage

// ----- hdl/swms_if.sv -----
// Valid/ready channel interfaces for the statistics block.
// Depends on nothing; time and length widths come from parameters.
interface swms_in_if #(parameter int unsigned TW = 48, parameter int unsigned LW = 16);
  logic valid;
  logic ready;
  logic cmd;
  logic [TW-1:0] msg_time;
  logic [1:0] level;
  logic [LW-1:0] msg_length;
  logic [TW-1:0] now_time;
  modport source(output valid, cmd, msg_time, level, msg_length, now_time, input ready);
  modport sink(input valid, cmd, msg_time, level, msg_length, now_time, output ready);
endinterface

interface swms_out_if #(parameter int unsigned LW = 16);
  logic valid;
  logic ready;
  logic [47:0] total_count;
  logic [47:0] level0_count;
  logic [47:0] level1_count;
  logic [47:0] level2_count;
  logic [LW-1:0] shortest_length;
  logic [LW-1:0] longest_length;
  logic [23:0] mean_length_q8;
  logic [10:0] window_count;
  logic [10:0] window_level0_count;
  logic [10:0] window_level1_count;
  logic [10:0] window_level2_count;
  logic [23:0] window_mean_q8;
  modport source(output valid, total_count, level0_count, level1_count, level2_count,
    shortest_length, longest_length, mean_length_q8, window_count, window_level0_count,
    window_level1_count, window_level2_count, window_mean_q8, input ready);
  modport sink(input valid, total_count, level0_count, level1_count, level2_count,
    shortest_length, longest_length, mean_length_q8, window_count, window_level0_count,
    window_level1_count, window_level2_count, window_mean_q8, output ready);
endinterface

interface swms_cfg_if;
  logic valid;
  logic ready;
  logic [26:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- hdl/sliding_window_message_stats.sv -----
// Sliding-window message statistics, top level.
// Record: push, then a read state and a compare state per FIFO entry examined.
// Snapshot: prune as above, then two serial divisions (each skipped when its
// divisor count is zero); one beat out.
// Throughput limited by the sequencer, which takes a new request only when idle, and the bit-serial divider.
// Reset clears all counters and empties the FIFO by its fill count; no clearing pass.
module sliding_window_message_stats #(
  parameter int unsigned WINDOW_DEPTH = swms_pkg::WindowDepth,
  parameter int unsigned LEN_BITS = swms_pkg::LenBits,
  parameter int unsigned TIME_BITS = swms_pkg::TimeBits
) (
  input logic  clk_i,
  input logic  rst_ni,
  swms_cfg_if.sink cfg,
  swms_in_if.sink  in_ch,
  swms_out_if.source out_ch
);
  import swms_pkg::*;
  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned FW = AW + 1;
  localparam int unsigned WSW = LEN_BITS + FW;
  localparam int unsigned EW = LEN_BITS + 2;
  localparam int unsigned NW = SumBits + 8;

  logic [TIME_BITS-1:0] stamp_mem [WINDOW_DEPTH];
  logic [EW-1:0]        ll_mem [WINDOW_DEPTH];
  logic [TIME_BITS-1:0] rd_stamp_q;
  logic [EW-1:0]        rd_ll_q;

  state_e state_q, state_d;
  logic [WinRegBits-1:0] win_q;
  logic [CntBits-1:0] all_q, lvl_q [3];
  logic [LEN_BITS:0] min_q;
  logic [LEN_BITS-1:0] max_q;
  logic [SumBits-1:0] sum_q;
  logic [AW-1:0] head_q;
  logic [FW-1:0] fill_q;
  logic [FW-1:0] wl_q [3];
  logic [WSW-1:0] wsum_q;
  logic cmd_q;
  logic [TIME_BITS-1:0] cut_q;
  logic [MeanBits-1:0] mean_q, wmean_q;
  logic div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [CntBits-1:0] div_den;
  logic [TIME_BITS-1:0] now_w;
  logic [AW-1:0] slot, rd_addr, head_inc;
  logic [FW-1:0] slot_sum;
  logic push_full;
  logic [TIME_BITS-1:0] msg_time_q;
  logic [1:0] level_q;
  logic [LEN_BITS-1:0] len_q;

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state_q == StIdle);
  assign out_ch.valid = (state_q == StOut);
  assign now_w = in_ch.now_time;
  assign push_full = (fill_q == FW'(WINDOW_DEPTH));
  assign slot_sum = FW'(head_q) + fill_q;
  assign slot = (slot_sum >= FW'(WINDOW_DEPTH)) ? AW'(slot_sum - FW'(WINDOW_DEPTH))
                                                : AW'(slot_sum);
  assign head_inc = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) win_q <= WinReset;
    else if (cfg.valid) win_q <= cfg.data;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_ch.valid) state_d = (in_ch.cmd == CmdRecord) ? StPush : StRead;
      StPush: state_d = StRead;
      StRead: state_d = (fill_q == '0) ? (cmd_q == CmdSnap ? StMeanA : StIdle) : StCheck;
      StCheck: begin
        if (rd_stamp_q < cut_q) state_d = StRead;
        else state_d = (cmd_q == CmdSnap) ? StMeanA : StIdle;
      end
      StMeanA: if (all_q == '0 || div_done) state_d = StMeanB;
      StMeanB: if (fill_q == '0 || div_done) state_d = StOut;
      StOut: if (out_ch.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  function automatic logic [MeanBits-1:0] sat_mean(input logic [NW-1:0] q);
    sat_mean = (q > NW'(MeanMax)) ? MeanMax : q[MeanBits-1:0];
  endfunction

  always_comb begin
    div_start = 1'b0;
    div_num = {sum_q, 8'd0};
    div_den = all_q;
    if (state_d == StMeanA && state_q != StMeanA) begin
      div_start = (all_q != '0);
    end else if (state_d == StMeanB && state_q != StMeanB) begin
      div_start = (fill_q != '0);
      div_num = NW'({wsum_q, 8'd0});
      div_den = CntBits'(fill_q);
    end
  end

  swms_div #(.NW(NW), .DW(CntBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  always_comb rd_addr = head_q;
  always_ff @(posedge clk_i) begin
    rd_stamp_q <= stamp_mem[rd_addr];
    rd_ll_q <= ll_mem[rd_addr];
    if (state_q == StPush) begin
      stamp_mem[slot] <= msg_time_q;
      ll_mem[slot] <= {level_q, len_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      all_q <= '0;
      lvl_q <= '{default: '0};
      min_q <= '1;
      max_q <= '0;
      sum_q <= '0;
      head_q <= '0;
      fill_q <= '0;
      wl_q <= '{default: '0};
      wsum_q <= '0;
      mean_q <= '0;
      wmean_q <= '0;
      cmd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle && in_ch.valid) begin
        cmd_q <= in_ch.cmd;
        cut_q <= (now_w >= TIME_BITS'(win_q)) ? now_w - TIME_BITS'(win_q) : '0;
        msg_time_q <= in_ch.msg_time;
        level_q <= in_ch.level;
        len_q <= in_ch.msg_length;
      end
      if (state_q == StPush) begin
        all_q <= all_q + 1'b1;
        if (level_q != 2'd3) lvl_q[level_q] <= lvl_q[level_q] + 1'b1;
        if (min_q[LEN_BITS] || len_q < min_q[LEN_BITS-1:0]) min_q <= {1'b0, len_q};
        if (len_q > max_q) max_q <= len_q;
        sum_q <= sum_q + SumBits'(len_q);
      end
      if (state_q == StCheck && rd_stamp_q < cut_q) begin
        if (rd_ll_q[EW-1 -: 2] != 2'd3)
          wl_q[rd_ll_q[EW-1 -: 2]] <= wl_q[rd_ll_q[EW-1 -: 2]] - 1'b1;
        wsum_q <= wsum_q - WSW'(rd_ll_q[LEN_BITS-1:0]);
        head_q <= head_inc;
        fill_q <= fill_q - 1'b1;
      end
      if (state_q == StPush) begin
        if (push_full) begin
          // evict oldest: its entry was read while idle
          head_q <= head_inc;
          wsum_q <= wsum_q - WSW'(rd_ll_q[LEN_BITS-1:0]) + WSW'(len_q);
          for (int i = 0; i < 3; i++) begin
            wl_q[i] <= wl_q[i] - FW'(rd_ll_q[EW-1 -: 2] == 2'(i))
                               + FW'(level_q == 2'(i));
          end
        end else begin
          fill_q <= fill_q + 1'b1;
          wsum_q <= wsum_q + WSW'(len_q);
          if (level_q != 2'd3) wl_q[level_q] <= wl_q[level_q] + 1'b1;
        end
      end
      if (state_q == StMeanA && state_d == StMeanB)
        mean_q <= (all_q == '0) ? '0 : sat_mean(div_quo);
      if (state_q == StMeanB && state_d == StOut)
        wmean_q <= (fill_q == '0) ? '0 : sat_mean(div_quo);
    end
  end

  assign out_ch.total_count = all_q;
  assign out_ch.level0_count = lvl_q[0];
  assign out_ch.level1_count = lvl_q[1];
  assign out_ch.level2_count = lvl_q[2];
  assign out_ch.shortest_length = min_q[LEN_BITS] ? '0 : min_q[LEN_BITS-1:0];
  assign out_ch.longest_length = max_q;
  assign out_ch.mean_length_q8 = mean_q;
  assign out_ch.window_count = WcntBits'(fill_q);
  assign out_ch.window_level0_count = WcntBits'(wl_q[0]);
  assign out_ch.window_level1_count = WcntBits'(wl_q[1]);
  assign out_ch.window_level2_count = WcntBits'(wl_q[2]);
  assign out_ch.window_mean_q8 = wmean_q;
endmodule

// ----- hdl/swms_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Standalone; used for the Q8 means.
module swms_div #(
  parameter int unsigned NW = 72,
  parameter int unsigned DW = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[DW-1:0], quo_q[NW-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

// ----- hdl/swms_checker.sv -----
// Port-level checker for the statistics block, bound to the top level.
// Depends on no package.
module swms_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [10:0] wcnt_i,
  input logic [10:0] wl0_i
);
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken while result pending");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  a_wcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_i <= 11'd1024) else $error("window count over depth");
  a_wl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wl0_i <= wcnt_i) else $error("level count over window count");
endmodule

bind sliding_window_message_stats swms_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
  .wcnt_i(out_ch.window_count), .wl0_i(out_ch.window_level0_count)
);

// ----- test/sliding_window_message_stats_tb.sv -----
// Testbench for the sliding-window message statistics block.
// Predicts every snapshot beat from its own model of the counters and window FIFO.
// Depends on swms_pkg and the channel interfaces in hdl/swms_if.sv.
module sliding_window_message_stats_tb;
  import swms_pkg::*;

  localparam int unsigned IdleLimit = 40000;
  localparam int unsigned SettleCycles = 2400;
  localparam int unsigned LongHold = 3000;
  localparam logic [WinRegBits-1:0] WinMax = '1;

  typedef struct packed {
    logic [CntBits-1:0] total;
    logic [CntBits-1:0] lvl0;
    logic [CntBits-1:0] lvl1;
    logic [CntBits-1:0] lvl2;
    logic [LenBits-1:0] shortest;
    logic [LenBits-1:0] longest;
    logic [MeanBits-1:0] mean;
    logic [WcntBits-1:0] wcount;
    logic [WcntBits-1:0] wlvl0;
    logic [WcntBits-1:0] wlvl1;
    logic [WcntBits-1:0] wlvl2;
    logic [MeanBits-1:0] wmean;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  swms_cfg_if cfg_ch ();
  swms_in_if #(.TW(TimeBits), .LW(LenBits)) in_ch ();
  swms_out_if #(.LW(LenBits)) out_ch ();

  sliding_window_message_stats uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg   (cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Own copy of the block state
  logic [WinRegBits-1:0] win_ms;
  logic [CntBits-1:0] msg_total;
  logic [CntBits-1:0] lvl_total[3];
  logic [16:0] len_min;
  logic [LenBits-1:0] len_max;
  logic [SumBits-1:0] len_sum;
  logic [TimeBits-1:0] slot_stamp[WindowDepth];
  logic [1:0] slot_level[WindowDepth];
  logic [LenBits-1:0] slot_len[WindowDepth];
  int unsigned head;
  int unsigned fill;
  int unsigned win_lvl[3];
  logic [SumBits-1:0] win_sum;

  stats_t snapshots_due[$];
  int unsigned errors = 0;
  int unsigned records_sent = 0;
  int unsigned snaps_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned burst_left = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_cycles = 0;
  int unsigned idle_cycles = 0;
  logic [TimeBits-1:0] clock_ms;

  function automatic logic [MeanBits-1:0] mean_q8(logic [SumBits-1:0] sum,
                                                  logic [SumBits-1:0] cnt);
    logic [SumBits-1:0] q, r, v;
    if (cnt == 0) return '0;
    q = sum / cnt;
    r = sum % cnt;
    if (q > (MeanMax >> 8)) return MeanMax;
    v = (q << 8) + (r << 8) / cnt;
    return (v > MeanMax) ? MeanMax : v[MeanBits-1:0];
  endfunction

  task automatic pop_oldest();
    if (fill == 0) return;
    if (slot_level[head] != 2'd3) win_lvl[slot_level[head]]--;
    win_sum -= SumBits'(slot_len[head]);
    head = (head + 1) % WindowDepth;
    fill--;
  endtask

  task automatic prune_window(logic [TimeBits-1:0] now);
    logic [TimeBits-1:0] cutoff;
    cutoff = (now >= win_ms) ? now - win_ms : '0;
    while (fill != 0 && slot_stamp[head] < cutoff) pop_oldest();
  endtask

  task automatic clear_stats();
    win_ms = WinReset;
    msg_total = '0;
    foreach (lvl_total[i]) lvl_total[i] = '0;
    foreach (win_lvl[i]) win_lvl[i] = 0;
    len_min = '1;
    len_max = '0;
    len_sum = '0;
    head = 0;
    fill = 0;
    win_sum = '0;
  endtask

  task automatic apply_item(logic cmd, logic [TimeBits-1:0] stamp, logic [1:0] lvl,
                            logic [LenBits-1:0] len, logic [TimeBits-1:0] now);
    stats_t s;
    int unsigned slot;
    if (cmd == CmdRecord) begin
      msg_total++;
      if (lvl != 2'd3) lvl_total[lvl]++;
      if (len_min == '1 || {1'b0, len} < len_min) len_min = {1'b0, len};
      if (len > len_max) len_max = len;
      len_sum += SumBits'(len);
      if (fill >= WindowDepth) pop_oldest();
      slot = (head + fill) % WindowDepth;
      slot_stamp[slot] = stamp;
      slot_level[slot] = lvl;
      slot_len[slot] = len;
      fill++;
      if (lvl != 2'd3) win_lvl[lvl]++;
      win_sum += SumBits'(len);
      prune_window(now);
      records_sent++;
    end else begin
      prune_window(now);
      s.total = msg_total;
      s.lvl0 = lvl_total[0];
      s.lvl1 = lvl_total[1];
      s.lvl2 = lvl_total[2];
      s.shortest = (len_min == '1) ? '0 : len_min[LenBits-1:0];
      s.longest = len_max;
      s.mean = mean_q8(len_sum, SumBits'(msg_total));
      s.wcount = WcntBits'(fill);
      s.wlvl0 = WcntBits'(win_lvl[0]);
      s.wlvl1 = WcntBits'(win_lvl[1]);
      s.wlvl2 = WcntBits'(win_lvl[2]);
      s.wmean = mean_q8(win_sum, SumBits'(fill));
      snapshots_due.insert(snapshots_due.size(), s);
    end
  endtask

  task automatic send_item(logic cmd, logic [TimeBits-1:0] stamp, logic [1:0] lvl,
                           logic [LenBits-1:0] len, logic [TimeBits-1:0] now);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.msg_time <= stamp;
    in_ch.level <= lvl;
    in_ch.msg_length <= len;
    in_ch.now_time <= now;
    do @(posedge clk_i); while (!in_ch.ready);
    apply_item(cmd, stamp, lvl, len, now);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (snapshots_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_window(logic [WinRegBits-1:0] value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    win_ms = value;
    cfg_writes++;
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch in snapshot %0d, %s: got %0d, want %0d", snaps_checked, field,
             got, want);
    errors++;
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_cycles = LongHold;
    end else if (hold_cycles != 0) begin
      hold_cycles--;
    end
  end

  always @(posedge clk_i) begin
    stats_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (snapshots_due.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = snapshots_due[0];
          snapshots_due.delete(0);
          check_field("total_count", out_ch.total_count, want.total);
          check_field("level0_count", out_ch.level0_count, want.lvl0);
          check_field("level1_count", out_ch.level1_count, want.lvl1);
          check_field("level2_count", out_ch.level2_count, want.lvl2);
          check_field("shortest_length", out_ch.shortest_length, want.shortest);
          check_field("longest_length", out_ch.longest_length, want.longest);
          check_field("mean_length_q8", out_ch.mean_length_q8, want.mean);
          check_field("window_count", out_ch.window_count, want.wcount);
          check_field("window_level0_count", out_ch.window_level0_count, want.wlvl0);
          check_field("window_level1_count", out_ch.window_level1_count, want.wlvl1);
          check_field("window_level2_count", out_ch.window_level2_count, want.wlvl2);
          check_field("window_mean_q8", out_ch.window_mean_q8, want.wmean);
        end
        snaps_checked++;
      end
      // hold off when asked, else stall on a slowly changing pattern
      if (hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
      end else if ((snaps_checked / 16) % 3 == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no beat for %0d cycles", IdleLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [TimeBits-1:0] rand_time();
    return TimeBits'({$urandom, $urandom});
  endfunction

  function automatic logic [LenBits-1:0] rand_len();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return LenBits'($urandom);
    endcase
  endfunction

  task automatic snap_at(logic [TimeBits-1:0] now);
    send_item(CmdSnap, rand_time(), 2'($urandom), LenBits'($urandom), now);
  endtask

  task automatic test_directed();
    snap_at('0);
    // early time: nothing pruned while now is below the window
    send_item(CmdRecord, '0, 2'd0, '0, '0);
    send_item(CmdRecord, 48'd5, 2'd1, '1, 48'd10);
    send_item(CmdRecord, 48'd7, 2'd2, 16'd1234, 48'd3599999);
    send_item(CmdRecord, 48'd8, 2'd3, 16'd77, 48'd3600000);
    snap_at(48'd3600000);
    // stale entry: pushed then pruned at once
    send_item(CmdRecord, 48'd1, 2'd1, 16'd500, 48'd4000000);
    snap_at(48'd4000000);
    snap_at(48'd9000000);
    send_item(CmdRecord, '1, 2'd3, '1, '1);
    send_item(CmdRecord, 48'h5555_5555_5555, 2'd2, 16'h5555, '1);
    send_item(CmdRecord, 48'hAAAA_AAAA_AAAA, 2'd1, 16'hAAAA, '1);
    snap_at('1);
    write_window(27'd1);
    send_item(CmdRecord, 48'd100, 2'd0, 16'd3, 48'd100);
    send_item(CmdRecord, 48'd99, 2'd1, 16'd4, 48'd100);
    send_item(CmdRecord, 48'd98, 2'd2, 16'd5, 48'd100);
    snap_at(48'd100);
    snap_at(48'd101);
    write_window(WinMax);
    snap_at(48'd200);
  endtask

  task automatic test_fifo_full();
    logic [TimeBits-1:0] t;
    t = 48'd500000000;
    for (int i = 0; i < WindowDepth + 60; i++) begin
      send_item(CmdRecord, t + i, 2'($urandom), rand_len(), t + i);
      if (i % 256 == 0) snap_at(t + i);
    end
    snap_at(t + WindowDepth + 60);
    clock_ms = t + WindowDepth + 60;
  endtask

  task automatic test_random_phase(logic [WinRegBits-1:0] win, int unsigned count);
    logic [TimeBits-1:0] step_max, stamp;
    write_window(win);
    step_max = (win > 64) ? win / 16 : 2;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) snap_at(rand_time());
        else send_item(CmdRecord, rand_time(), 2'($urandom), rand_len(), rand_time());
        continue;
      end
      clock_ms += $urandom_range(0, 32'(step_max));
      stamp = clock_ms - $urandom_range(0, (win < 8) ? 3 : win + win / 4);
      if ($urandom_range(0, 5) == 0) snap_at(clock_ms);
      else send_item(CmdRecord, stamp, 2'($urandom), rand_len(), clock_ms);
    end
    snap_at(clock_ms);
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    for (int i = 0; i < 40; i++) begin
      clock_ms += $urandom_range(0, 3);
      if (i % 2) snap_at(clock_ms);
      else send_item(CmdRecord, clock_ms, 2'($urandom), rand_len(), clock_ms);
    end
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      clock_ms += 1;
      send_item(CmdRecord, clock_ms, 2'($urandom), rand_len(), clock_ms);
    end
    snap_at(clock_ms);
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CmdRecord;
    in_ch.msg_time = '0;
    in_ch.level = '0;
    in_ch.msg_length = '0;
    in_ch.now_time = '0;
    clear_stats();
    clock_ms = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fifo_full();
    test_random_phase(27'd1, 150);
    test_random_phase(27'd50, 150);
    test_random_phase(27'd1000, 150);
    test_backpressure();
    test_random_phase(WinReset, 100);
    test_random_phase(27'd86400000, 100);
    test_random_phase(WinMax, 100);
    wait_drained();
    $display("covered %0d records, %0d snapshots checked, %0d window writes",
             records_sent, snaps_checked, cfg_writes);
    $display("including a full window FIFO, stale entries, level three and a long stall");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
